FILE: hdl/sot_pkg.sv
// shared types and constants of the section offset translator
`timescale 1ns / 1ps
package sot_pkg;

  localparam int MAX_SECTIONS_DEFAULT = 16;

  localparam int ADDR_W      = 32;
  localparam int NAME_W      = 64;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic FUNC_LOAD      = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_COUNT = 4'd1;

  localparam logic DIR_FILE_TO_VIRT = 1'b0;
  localparam logic DIR_VIRT_TO_FILE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] entry_index;
    logic [ADDR_W-1:0] entry_virtual_start;
    logic [ADDR_W-1:0] entry_file_offset;
    logic [ADDR_W-1:0] entry_raw_size;
    logic [NAME_W-1:0] entry_name;
    logic [ADDR_W-1:0] lookup_address;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] translated_address;
    logic              found;
    logic [SLOT_W-1:0] hit_index;
    logic [NAME_W-1:0] hit_name;
  } result_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ADDR_W-1:0] raw_size;
    logic [ADDR_W-1:0] file_offset;
    logic [ADDR_W-1:0] virtual_start;
  } entry_t;

  typedef struct packed {
    logic               direction;
    logic [COUNT_W-1:0] section_count;
  } cfg_t;

endpackage

FILE: hdl/section_offset_translator.sv
// top level of the section offset translator: config registers, walker and table ram
//
//  channel  | signals                                  | beat taken when
//  ---------+------------------------------------------+---------------------------
//  command  | start, busy, item                        | start && !busy
//  result   | done, result                             | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
//  a load writes its table slot when taken; its zero result comes on the next cycle
//  a translate walks one table entry a cycle through the ram's read port
//  and stops at the first hit or after the last searched entry
//  reset clears the direction (to virtual-to-file), count and control; table is not cleared
//  the receiver cannot stall; config is always ready
`timescale 1ns / 1ps
module section_offset_translator #(
  parameter int MAX_SECTIONS = sot_pkg::MAX_SECTIONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  sot_pkg::item_t                     item,
  output logic                               done,
  output sot_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sot_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sot_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int EW = $bits(sot_pkg::entry_t);

  sot_pkg::cfg_t cfg;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction     <= sot_pkg::DIR_VIRT_TO_FILE;
      cfg.section_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sot_pkg::CFG_DIRECTION:     cfg.direction     <= cfg_data[0];
        sot_pkg::CFG_SECTION_COUNT: cfg.section_count <= cfg_data[sot_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sot_walker #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .IW           (IW)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg       (cfg),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sot_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: hdl/sot_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module sot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sot_walker.sv
// command control, section table walk and range match
`timescale 1ns / 1ps
module sot_walker #(
  parameter int MAX_SECTIONS = sot_pkg::MAX_SECTIONS_DEFAULT,
  parameter int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sot_pkg::item_t                   item,
  input  sot_pkg::cfg_t                    cfg,
  output logic                             done,
  output sot_pkg::result_t                 result,
  output logic                             ram_we,
  output logic [IW-1:0]                    ram_waddr,
  output logic [$bits(sot_pkg::entry_t)-1:0] ram_wdata,
  output logic                             ram_re,
  output logic [IW-1:0]                    ram_raddr,
  input  logic [$bits(sot_pkg::entry_t)-1:0] ram_rdata
);

  localparam int CW = $clog2(MAX_SECTIONS + 1);

  sot_pkg::state_t  state, state_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic             chk_valid, chk_valid_next;
  logic [IW-1:0]    chk_idx, chk_idx_next;
  logic [sot_pkg::ADDR_W-1:0] lookup;
  logic             done_next;
  sot_pkg::result_t result_next;

  logic [CW-1:0]    count;
  logic             issue;
  logic             slot_ok;
  sot_pkg::entry_t  wr_entry;
  sot_pkg::entry_t  rd_entry;
  logic [sot_pkg::ADDR_W-1:0] from_addr, to_addr, diff;
  logic             hit;

  // clamp the searched count to the table depth
  assign count = (32'(cfg.section_count) > 32'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS)
                                                               : CW'(cfg.section_count);
  assign slot_ok = 32'(item.entry_index) < 32'(MAX_SECTIONS);
  assign issue   = ptr < count;
  assign busy    = state != sot_pkg::ST_IDLE;

  assign wr_entry.name          = item.entry_name;
  assign wr_entry.raw_size      = item.entry_raw_size;
  assign wr_entry.file_offset   = item.entry_file_offset;
  assign wr_entry.virtual_start = item.entry_virtual_start;
  assign ram_wdata = wr_entry;
  assign ram_waddr = IW'(item.entry_index);
  assign ram_raddr = ptr[IW-1:0];
  assign rd_entry  = ram_rdata;

  assign from_addr = (cfg.direction == sot_pkg::DIR_VIRT_TO_FILE) ? rd_entry.virtual_start
                                                                  : rd_entry.file_offset;
  assign to_addr   = (cfg.direction == sot_pkg::DIR_VIRT_TO_FILE) ? rd_entry.file_offset
                                                                  : rd_entry.virtual_start;
  assign diff = lookup - from_addr;
  assign hit  = chk_valid && (lookup >= from_addr) && (diff < rd_entry.raw_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sot_pkg::ST_IDLE;
      ptr       <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      chk_valid <= chk_valid_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= chk_idx_next;
    result  <= result_next;
    if (start && !busy) begin
      lookup <= item.lookup_address;
    end
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    chk_valid_next = 1'b0;
    chk_idx_next   = chk_idx;
    done_next      = 1'b0;
    result_next    = result;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    case (state)
      sot_pkg::ST_IDLE: begin
        if (start) begin
          if (item.func == sot_pkg::FUNC_LOAD) begin
            ram_we      = slot_ok;
            done_next   = 1'b1;
            result_next = '0;
          end else begin
            state_next = sot_pkg::ST_SCAN;
            ptr_next   = '0;
          end
        end
      end
      sot_pkg::ST_SCAN: begin
        ram_re = issue;
        if (issue) begin
          ptr_next       = ptr + CW'(1);
          chk_valid_next = 1'b1;
          chk_idx_next   = ptr[IW-1:0];
        end
        if (hit) begin
          chk_valid_next                 = 1'b0;
          done_next                      = 1'b1;
          result_next.translated_address = to_addr + diff;
          result_next.found              = 1'b1;
          result_next.hit_index          = sot_pkg::SLOT_W'(chk_idx);
          result_next.hit_name           = rd_entry.name;
          state_next                     = sot_pkg::ST_IDLE;
        end else if (!issue) begin
          // last entry checked, or nothing to search
          done_next   = 1'b1;
          result_next = '0;
          state_next  = sot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sot_pkg::ST_IDLE;
      end
    endcase
  end

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.translated_address == '0 && result.hit_index == '0
                              && result.hit_name == '0)
    else $error("not-found beat carries nonzero fields");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == sot_pkg::ST_IDLE && start)
    else $error("table written outside an accepted load");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    state == sot_pkg::ST_SCAN |-> ptr <= count)
    else $error("walk pointer passed the section count");

  a_translate_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == sot_pkg::FUNC_TRANSLATE |=> busy && !done)
    else $error("translate did not start a walk");

  a_load_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == sot_pkg::FUNC_LOAD |=> done && !result.found)
    else $error("load gave no zero beat");

endmodule

FILE: test/tb.sv
// testbench for the section offset translator: directed and random loads, lookups and config
`timescale 1ns / 1ps
module tb;
  import sot_pkg::*;

  localparam int SECTIONS = MAX_SECTIONS_DEFAULT;

  class translation_scoreboard;
    logic [ADDR_W-1:0]  virt_start[SECTIONS];
    logic [ADDR_W-1:0]  file_off[SECTIONS];
    logic [ADDR_W-1:0]  raw_size[SECTIONS];
    logic [NAME_W-1:0]  sect_name[SECTIONS];
    logic               dir;
    logic [COUNT_W-1:0] count;
    result_t            expected_q[$];
    int                 errors;
    int                 loads;
    int                 hits;
    int                 misses;

    function new();
      dir    = DIR_VIRT_TO_FILE;
      count  = '0;
      errors = 0;
      loads  = 0;
      hits   = 0;
      misses = 0;
    endfunction

    function int searched();
      return (count > SECTIONS) ? SECTIONS : count;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DIRECTION) begin
        dir = data[0];
      end else if (idx == CFG_SECTION_COUNT) begin
        count = data[COUNT_W-1:0];
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      int n;
      logic [ADDR_W-1:0] from, to, off;
      r = '0;
      if (it.func == FUNC_LOAD) begin
        virt_start[it.entry_index] = it.entry_virtual_start;
        file_off[it.entry_index]   = it.entry_file_offset;
        raw_size[it.entry_index]   = it.entry_raw_size;
        sect_name[it.entry_index]  = it.entry_name;
        loads++;
      end else begin
        n = searched();
        for (int i = 0; i < n && !r.found; i++) begin
          from = (dir == DIR_VIRT_TO_FILE) ? virt_start[i] : file_off[i];
          to   = (dir == DIR_VIRT_TO_FILE) ? file_off[i] : virt_start[i];
          off  = it.lookup_address - from;
          if (it.lookup_address >= from && off < raw_size[i]) begin
            r.translated_address = to + off;
            r.found              = 1'b1;
            r.hit_index          = i[SLOT_W-1:0];
            r.hit_name           = sect_name[i];
          end
        end
        if (r.found) hits++;
        else misses++;
      end
      expected_q.push_back(r);
    endfunction

    function void field_check(string field, logic [63:0] exp, logic [63:0] got);
      if (exp !== got) begin
        $display("%0t: mismatch on %s expected %h got %h", $time, field, exp, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      field_check("translated_address", 64'(exp.translated_address),
                  64'(got.translated_address));
      field_check("found", 64'(exp.found), 64'(got.found));
      field_check("hit_index", 64'(exp.hit_index), 64'(got.hit_index));
      field_check("hit_name", 64'(exp.hit_name), 64'(got.hit_name));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  translation_scoreboard sb = new();
  int cfg_writes = 0;

  always #6 clk = ~clk;

  section_offset_translator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic send(input item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic d, input int n);
    write_reg(CFG_DIRECTION, ($urandom & ~32'h1) | d);
    write_reg(CFG_SECTION_COUNT, ($urandom & ~32'h1F) | n[COUNT_W-1:0]);
  endtask

  function automatic item_t make_load(input int slot, input entry_t e);
    item_t it;
    it.func                = FUNC_LOAD;
    it.entry_index         = slot[SLOT_W-1:0];
    it.entry_virtual_start = e.virtual_start;
    it.entry_file_offset   = e.file_offset;
    it.entry_raw_size      = e.raw_size;
    it.entry_name          = e.name;
    it.lookup_address      = $urandom;
    return it;
  endfunction

  function automatic item_t make_lookup(input logic [ADDR_W-1:0] addr);
    item_t it;
    it.func                = FUNC_TRANSLATE;
    it.entry_index         = SLOT_W'($urandom_range(0, SECTIONS - 1));
    it.entry_virtual_start = $urandom;
    it.entry_file_offset   = $urandom;
    it.entry_raw_size      = $urandom;
    it.entry_name          = {$urandom, $urandom};
    it.lookup_address      = addr;
    return it;
  endfunction

  function automatic entry_t fixed_entry(input int i);
    entry_t e;
    e.virtual_start = 32'h0010_0000 * i;
    e.file_offset   = 32'h0001_0000 * i;
    e.raw_size      = 32'h100;
    e.name          = {8{8'(8'h41 + i)}};
    case (i)
      0: begin
        e.virtual_start = 32'h0000_1000;
        e.file_offset   = 32'h0000_0400;
        e.raw_size      = 32'h200;
      end
      1: begin
        e.virtual_start = 32'h0000_1100;
        e.file_offset   = 32'h0000_0800;
        e.raw_size      = 32'h400;
      end
      2: begin
        e.virtual_start = 32'hFFFF_FF00;
        e.file_offset   = 32'h0000_2000;
        e.raw_size      = 32'h300;
      end
      3: begin
        e.virtual_start = 32'h0000_5000;
        e.file_offset   = 32'h0000_3000;
        e.raw_size      = 32'h0;
        e.name          = '0;
      end
      4: begin
        e.virtual_start = 32'h0000_6000;
        e.file_offset   = 32'hFFFF_F000;
        e.raw_size      = 32'h1000;
      end
      15: begin
        e.virtual_start = 32'hFFFF_FFFF;
        e.file_offset   = 32'hFFFF_FFFF;
        e.raw_size      = 32'hFFFF_FFFF;
        e.name          = '1;
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    int r;
    r = $urandom_range(0, 9);
    e.name          = {$urandom, $urandom};
    e.virtual_start = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3FFFF);
    e.file_offset   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3FFFF);
    case (r)
      0: e.raw_size = '0;
      1: e.raw_size = $urandom;
      2: begin
        // may reach past the top of the address space
        e.virtual_start = 32'hFFFF_0000 | ($urandom & 32'hFFFF);
        e.file_offset   = 32'hFFFF_0000 | ($urandom & 32'hFFFF);
        e.raw_size      = $urandom_range(1, 32'h20000);
      end
      default: e.raw_size = $urandom_range(1, 32'h10000);
    endcase
    return e;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int n, i, r;
    logic [ADDR_W-1:0] from, sz;
    n = sb.searched();
    r = $urandom_range(0, 99);
    if (n == 0 || r < 20) return $urandom;
    i    = $urandom_range(0, n - 1);
    from = (sb.dir == DIR_VIRT_TO_FILE) ? sb.virt_start[i] : sb.file_off[i];
    sz   = sb.raw_size[i];
    if (r < 30) return from + sz;
    if (r < 36) return from - 1;
    if (sz == 0 || r < 42) return from;
    if (r < 50) return from + sz - 1;
    return from + ($urandom % sz);
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int n;
    bit quiet;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: empty search, table fill, then each corner
    send(make_lookup(32'h0));
    for (int i = 0; i < SECTIONS; i++) begin
      send(make_load(i, fixed_entry(i)));
      pause(pick_gap(1'b0));
    end
    drain();
    write_reg(CFG_INDEX_W'($urandom_range(2, 15)), $urandom);
    set_mode(DIR_VIRT_TO_FILE, 31);
    send(make_lookup(32'h0000_1000));
    send(make_lookup(32'h0000_1150));
    send(make_lookup(32'h0000_1200));
    send(make_lookup(32'hFFFF_FFFF));
    send(make_lookup(32'h0000_5000));
    send(make_lookup(32'h0000_6FFF));
    drain();
    set_mode(DIR_FILE_TO_VIRT, 5);
    send(make_lookup(32'h0000_0400));
    send(make_lookup(32'h0000_3000));
    send(make_lookup(32'hFFFF_FFFF));
    drain();

    // random part
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: n = 16;
        1: n = 0;
        2: n = 31;
        3: n = 17;
        default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, 16);
      endcase
      write_reg(CFG_INDEX_W'($urandom_range(2, 15)), $urandom);
      set_mode((p < 4) ? p[0] : 1'($urandom_range(0, 1)), n);
      quiet = (p % 3 == 2);
      for (int k = 0; k < 160; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send(make_load($urandom_range(0, SECTIONS - 1), random_entry()));
        end else begin
          send(make_lookup(pick_address()));
        end
        if ($urandom_range(0, 99) == 0) drain();
        else pause(pick_gap(quiet));
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d table loads, %0d lookups that hit and %0d that missed,",
             sb.loads, sb.hits, sb.misses);
    $display("over %0d register writes in both directions and counts from 0 to 31",
             cfg_writes);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sot_pkg.sv
hdl/sot_ram.sv
hdl/sot_walker.sv
hdl/section_offset_translator.sv
test/tb.sv
